// ----- src/dtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_pkg: shared definitions for the disparity reprojection block
// Field widths, register indexes, divider sizes and the flag bundle that
// travels with each item from the front end to the back end.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // Field and register widths
  localparam int COL_W  = 12;
  localparam int DISP_W = 8;
  localparam int CX_W   = 20;
  localparam int REG_W  = 32;
  localparam int NEAR_W = 9;
  localparam int IDX_W  = 4;
  localparam int OUT_W  = 32;

  // Defaults of the top-level parameters
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // A positive w always fits in this many bits
  localparam int W_W = 41;
  // Quotient bits produced by the divider; larger quotients saturate
  localparam int QB  = 33;
  // Queue depth between the front and back ends
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X  = 4'd0,
    REG_CENTER_Y  = 4'd1,
    REG_Y_SCALE   = 4'd2,
    REG_FOCAL_X   = 4'd3,
    REG_W_GAIN    = 4'd4,
    REG_W_OFFSET  = 4'd5,
    REG_DISP_NEAR = 4'd6,
    REG_DISP_FAR  = 4'd7
  } reg_idx_t;

  // Per-item flags: point kept, and signs of the x and y terms
  typedef struct packed {
    logic ok;
    logic x_neg;
    logic y_neg;
  } pt_flags_t;

  localparam int FLAGS_W = $bits(pt_flags_t);

endpackage

// ----- src/dtp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_if: channel interfaces of the disparity reprojection block
// Pixel input channel, point output channel and register write channel.
// ----------------------------------------------------------------------------
interface dtp_in_if;
  import dtp_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column;
  logic [COL_W-1:0]  row;
  logic [DISP_W-1:0] disparity;
  modport source (output valid, column, row, disparity, input ready);
  modport sink   (input valid, column, row, disparity, output ready);
endinterface

interface dtp_out_if;
  import dtp_pkg::*;
  logic             valid;
  logic             ready;
  logic             point_valid;
  logic [OUT_W-1:0] point_x;
  logic [OUT_W-1:0] point_y;
  logic [OUT_W-1:0] point_z;
  modport source (output valid, point_valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_valid, point_x, point_y, point_z, output ready);
endinterface

interface dtp_cfg_if;
  import dtp_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/dtp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_front: register file, gating and homogeneous point terms
// Holds the configuration, gates each pixel on disparity and on w, and forms the
// scaled numerators and the w denominator over two pipeline stages.
// ----------------------------------------------------------------------------
module dtp_front #(
  parameter int COORD_BITS = dtp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dtp_pkg::FRAC_BITS_DEF,
  localparam int NUM_W     = 48 + FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dtp_in_if.sink                in_if,
  dtp_cfg_if.sink               cfg_if,
  output logic                  push_valid,
  input  logic                  push_ready,
  output dtp_pkg::pt_flags_t    push_flags,
  output logic [dtp_pkg::W_W-1:0] push_den,
  output logic [NUM_W-1:0]      push_num_x,
  output logic [NUM_W-1:0]      push_num_y,
  output logic [NUM_W-1:0]      push_num_z
);
  import dtp_pkg::*;

  localparam int CB    = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
  localparam logic [COL_W-1:0] CMASK = COL_W'((64'd1 << CB) - 64'd1);
  localparam int XT_W  = CX_W + 1;
  localparam int WF_W  = W_W + 1;
  localparam int WP_W  = DISP_W + REG_W;

  logic [CX_W-1:0]   center_x_r, center_y_r;
  logic [REG_W-1:0]  y_scale_r, focal_x_r, w_gain_r, w_offset_r;
  logic [NEAR_W-1:0] disp_near_r;
  logic [DISP_W-1:0] disp_far_r;

  // Register writes; indexes past the list are dropped
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      y_scale_r   <= 32'd65536;
      focal_x_r   <= 32'd65536;
      w_gain_r    <= 32'd65536;
      w_offset_r  <= '0;
      disp_near_r <= 9'd256;
      disp_far_r  <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_CENTER_X:  center_x_r  <= cfg_if.data[CX_W-1:0];
        REG_CENTER_Y:  center_y_r  <= cfg_if.data[CX_W-1:0];
        REG_Y_SCALE:   y_scale_r   <= cfg_if.data;
        REG_FOCAL_X:   focal_x_r   <= cfg_if.data;
        REG_W_GAIN:    w_gain_r    <= cfg_if.data;
        REG_W_OFFSET:  w_offset_r  <= cfg_if.data;
        REG_DISP_NEAR: disp_near_r <= cfg_if.data[NEAR_W-1:0];
        REG_DISP_FAR:  disp_far_r  <= cfg_if.data[DISP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: each stage moves when the one after it can take an item
  logic s1_v_r, s2_v_r;
  logic en1, en2;
  assign en2 = !s2_v_r || push_ready;
  assign en1 = !s1_v_r || en2;
  assign in_if.ready = en1;

  // Stage 1: gates, w, and the centred coordinates
  logic [WP_W-1:0]  wprod;
  logic [WF_W-1:0]  w_nxt;
  logic [COL_W-1:0] u_m, v_m;
  logic [XT_W-1:0]  xt_nxt, yd_nxt;
  logic             ok_nxt;

  always_comb begin
    wprod  = w_gain_r * in_if.disparity;
    w_nxt  = {{(WF_W-WP_W){1'b0}}, wprod}
           - {{(WF_W-REG_W){w_offset_r[REG_W-1]}}, w_offset_r};
    u_m    = in_if.column & CMASK;
    v_m    = in_if.row & CMASK;
    xt_nxt = {{(XT_W-COL_W-4){1'b0}}, u_m, 4'b0000} - {1'b0, center_x_r};
    yd_nxt = {{(XT_W-COL_W-4){1'b0}}, v_m, 4'b0000} - {1'b0, center_y_r};
    ok_nxt = ({1'b0, in_if.disparity} < disp_near_r) && (in_if.disparity > disp_far_r)
           && !w_nxt[WF_W-1] && (w_nxt[W_W-1:0] != '0);
  end

  logic [W_W-1:0]  s1_w_r;
  logic [XT_W-1:0] s1_xt_r, s1_yd_r;
  logic            s1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_w_r  <= w_nxt[W_W-1:0];
      s1_xt_r <= xt_nxt;
      s1_yd_r <= yd_nxt;
      s1_ok_r <= ok_nxt;
    end
  end

  // Stage 2: magnitudes, y scaling and alignment of the numerators
  logic [XT_W-1:0]       xabs, yabs;
  logic [CX_W+REG_W-1:0] yprod;

  always_comb begin
    xabs  = s1_xt_r[XT_W-1] ? (XT_W'(0) - s1_xt_r) : s1_xt_r;
    yabs  = s1_yd_r[XT_W-1] ? (XT_W'(0) - s1_yd_r) : s1_yd_r;
    yprod = yabs[CX_W-1:0] * y_scale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      push_flags.ok    <= s1_ok_r;
      push_flags.x_neg <= s1_xt_r[XT_W-1];
      push_flags.y_neg <= s1_yd_r[XT_W-1];
      push_den   <= s1_w_r;
      push_num_x <= {{(NUM_W-CX_W-12-FRAC_BITS){1'b0}}, xabs[CX_W-1:0],
                     {(12+FRAC_BITS){1'b0}}};
      push_num_y <= {yprod, {(FRAC_BITS-4){1'b0}}};
      push_num_z <= {{(NUM_W-REG_W-FRAC_BITS){1'b0}}, focal_x_r, {FRAC_BITS{1'b0}}};
    end
  end

  assign push_valid = s2_v_r;

endmodule

// ----- src/dtp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_queue: short item queue between the front and back ends
// A small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
module dtp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dtp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import dtp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/dtp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_div: pipelined restoring divider
// One quotient bit per stage; an up-front compare flags quotients too large
// for the quotient width, which the caller saturates.
// ----------------------------------------------------------------------------
module dtp_div #(
  parameter int NUM_W = 64
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [NUM_W-1:0]        num,
  input  logic [dtp_pkg::W_W-1:0] den,
  output logic [dtp_pkg::QB-1:0]  quo,
  output logic [dtp_pkg::W_W-1:0] rem,
  output logic [dtp_pkg::W_W-1:0] den_o,
  output logic                    ovf
);
  import dtp_pkg::*;

  localparam int HI_W = NUM_W - QB;

  logic [W_W-1:0] rem_r [QB+1];
  logic [QB-1:0]  quo_r [QB+1];
  logic [QB-1:0]  low_r [QB+1];
  logic [W_W-1:0] den_r [QB+1];
  logic           ovf_r [QB+1];

  // Load stage: the high dividend bits must already be below the divisor
  logic [W_W:0] hi_ext;
  logic         ovf_nxt;
  assign hi_ext  = {{(W_W+1-HI_W){1'b0}}, num[NUM_W-1:QB]};
  assign ovf_nxt = hi_ext >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf_nxt ? '0 : hi_ext[W_W-1:0];
      quo_r[0] <= '0;
      low_r[0] <= num[QB-1:0];
      den_r[0] <= den;
      ovf_r[0] <= ovf_nxt;
    end
  end

  // One trial subtraction per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [W_W:0] trial;
    logic         ge;
    assign trial = {rem_r[k], low_r[k][QB-1-k]};
    assign ge    = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? W_W'(trial - {1'b0, den_r[k]}) : trial[W_W-1:0];
        quo_r[k+1] <= {quo_r[k][QB-2:0], ge};
        low_r[k+1] <= low_r[k];
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo   = quo_r[QB];
  assign rem   = rem_r[QB];
  assign den_o = den_r[QB];
  assign ovf   = ovf_r[QB];

endmodule

// ----- src/dtp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_back: division, rounding and saturation of the point coordinates
// Three dividers share one stall signal; the last stage rounds to nearest,
// saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module dtp_back #(
  parameter int FRAC_BITS = dtp_pkg::FRAC_BITS_DEF,
  localparam int NUM_W    = 48 + FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  dtp_pkg::pt_flags_t      pop_flags,
  input  logic [dtp_pkg::W_W-1:0] pop_den,
  input  logic [NUM_W-1:0]        pop_num_x,
  input  logic [NUM_W-1:0]        pop_num_y,
  input  logic [NUM_W-1:0]        pop_num_z,
  dtp_out_if.source               out_if
);
  import dtp_pkg::*;

  localparam logic [QB:0] POS_MAX = (QB+1)'(64'h7FFF_FFFF);
  localparam logic [QB:0] NEG_MAX = (QB+1)'(64'h8000_0000);

  // Round to nearest, ties away from zero, then saturate
  function automatic logic [OUT_W-1:0] finish(input logic neg, input logic [QB-1:0] q,
                                              input logic [W_W-1:0] r,
                                              input logic [W_W-1:0] d, input logic big);
    logic        up;
    logic [QB:0] qr;
    logic [QB:0] nq;
    up = {r, 1'b0} >= {1'b0, d};
    qr = {1'b0, q} + {{QB{1'b0}}, up};
    nq = (QB+1)'(0) - qr;
    if (!neg) begin
      finish = (big || qr > POS_MAX) ? POS_MAX[OUT_W-1:0] : qr[OUT_W-1:0];
    end else begin
      finish = (big || qr > NEG_MAX) ? NEG_MAX[OUT_W-1:0] : nq[OUT_W-1:0];
    end
  endfunction

  logic en;
  logic out_v_r;
  assign en        = !out_v_r || out_if.ready;
  assign pop_ready = en;

  // Valid and flag line alongside the divider stages
  logic      v_r [QB+1];
  pt_flags_t f_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= pop_valid;
      for (int i = 0; i < QB; i++) v_r[i+1] <= v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= pop_flags;
      for (int i = 0; i < QB; i++) f_r[i+1] <= f_r[i];
    end
  end

  // Dividers for X, Y and Z
  logic [QB-1:0]  qx, qy, qz;
  logic [W_W-1:0] rx, ry, rz, dx, dy, dz;
  logic           ox, oy, oz;

  dtp_div #(.NUM_W(NUM_W)) u_div_x (
    .clk(clk), .en(en), .num(pop_num_x), .den(pop_den),
    .quo(qx), .rem(rx), .den_o(dx), .ovf(ox)
  );
  dtp_div #(.NUM_W(NUM_W)) u_div_y (
    .clk(clk), .en(en), .num(pop_num_y), .den(pop_den),
    .quo(qy), .rem(ry), .den_o(dy), .ovf(oy)
  );
  dtp_div #(.NUM_W(NUM_W)) u_div_z (
    .clk(clk), .en(en), .num(pop_num_z), .den(pop_den),
    .quo(qz), .rem(rz), .den_o(dz), .ovf(oz)
  );

  // Output register; rejected pixels give all zeros
  logic             pv_r;
  logic [OUT_W-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv_r <= f_r[QB].ok;
      px_r <= f_r[QB].ok ? finish(f_r[QB].x_neg, qx, rx, dx, ox) : '0;
      py_r <= f_r[QB].ok ? finish(f_r[QB].y_neg, qy, ry, dy, oy) : '0;
      pz_r <= f_r[QB].ok ? finish(1'b0, qz, rz, dz, oz) : '0;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.point_valid = pv_r;
  assign out_if.point_x     = px_r;
  assign out_if.point_y     = py_r;
  assign out_if.point_z     = pz_r;

endmodule

// ----- src/disparity_to_point_reprojection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection: stereo disparity to 3-D point reprojection
// Turns each disparity pixel into a signed fixed-point X, Y, Z point.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one pixel per item (column, row, disparity); out_if returns
//   exactly one point per pixel, in order, with point_valid low and zero
//   coordinates for pixels outside the disparity gates or with w not positive.
//   cfg_if writes the camera registers by index; it is always ready, and
//   should only be written while no item is in flight.
//   Throughput is one item per clock while out_if.ready is high. Items pass
//   two front stages, the queue, a load stage plus 33 divider stages (one
//   quotient bit per stage, which sets the depth) and the output register.
//   Reset is synchronous, active low: it empties the pipeline and the queue
//   and returns every configuration register to its default.
//   When the receiver stalls, the back end holds in place; the queue and the
//   front stages keep taking items until they fill, and then in_if.ready
//   drops. No item is lost or repeated.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection #(
  parameter int COORD_BITS = dtp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dtp_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dtp_in_if.sink     in_if,
  dtp_out_if.source  out_if,
  dtp_cfg_if.sink    cfg_if
);
  import dtp_pkg::*;

  localparam int NUM_W = 48 + FRAC_BITS;
  localparam int Q_W   = FLAGS_W + W_W + 3 * NUM_W;

  logic           push_valid, push_ready, pop_valid, pop_ready;
  pt_flags_t      push_flags, pop_flags;
  logic [W_W-1:0] push_den, pop_den;
  logic [NUM_W-1:0] push_nx, push_ny, push_nz, pop_nx, pop_ny, pop_nz;
  logic [Q_W-1:0] push_data, pop_data;

  dtp_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .cfg_if(cfg_if),
    .push_valid(push_valid), .push_ready(push_ready), .push_flags(push_flags),
    .push_den(push_den), .push_num_x(push_nx), .push_num_y(push_ny),
    .push_num_z(push_nz)
  );

  // Pack and unpack queue entries
  assign push_data = {push_flags, push_den, push_nx, push_ny, push_nz};
  assign {pop_flags, pop_den, pop_nx, pop_ny, pop_nz} = pop_data;

  dtp_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  dtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_flags(pop_flags),
    .pop_den(pop_den), .pop_num_x(pop_nx), .pop_num_y(pop_ny), .pop_num_z(pop_nz),
    .out_if(out_if)
  );

endmodule
